// ===== design/sbad_pkg.sv =====
// ----------------------------------------------------------------------------
// sbad_pkg: shared constants and helpers for the signed binary to decimal
// text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbad_pkg;

	localparam int VALUE_BITS_DEFAULT = 16;

	localparam logic [7:0] MINUS_CODE = 8'd45;
	localparam logic [7:0] ZERO_CODE  = 8'd48;
	localparam logic [3:0] RADIX      = 4'd10;

	// n / 10 == (n * RECIP) >> RECIP_SHIFT, exact for every n below 2**32
	localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Decimal digits needed for a magnitude of up to 2**(bits-1).
	function automatic int digits_for(input int bits);
		digits_for = ((bits - 1) * 30103) / 100000 + 1;
	endfunction

endpackage

`default_nettype wire

// ===== design/signed_binary_to_ascii_decimal.sv =====
// Pipeline: one magnitude stage, NDIG divide-by-ten stages and one character register
//   lie between an input transfer and its first character.
// Throughput: one character per cycle while m_axis_tready is high; an item is sent
//   as 1 to 6 characters at 16 bits, and the next item may load as its last one goes.
// Reset: arst_n clears all valid bits and the character sequencer; no data held.
// ----------------------------------------------------------------------------
// signed_binary_to_ascii_decimal: signed integer to ASCII decimal text
// Pipelined digit extraction feeding a character sequencer, sign first.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_ascii_decimal #(
	parameter int VALUE_BITS = sbad_pkg::VALUE_BITS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [7:0]                               m_axis_tdata,  // char_code
	output logic                                     m_axis_tlast
);
	import sbad_pkg::*;

	localparam int NDIG = digits_for(VALUE_BITS);
	localparam int NDW  = $clog2(NDIG + 2);
	localparam int IW   = $clog2(NDIG);

	// stage k of the arrays feeds digit stage k; index 0 is the magnitude stage
	logic [NDIG:0]                 vld_a;
	logic [NDIG:0]                 neg_a;
	logic [VALUE_BITS-1:0]         quo_a [NDIG+1];
	logic [NDW-1:0]                nd_a  [NDIG+1];
	logic [NDIG-1:0][3:0]          dig_a [NDIG+1];

	logic                          vld_s1;
	logic                          neg_s1;
	logic [VALUE_BITS-1:0]         quo_s1;

	logic                          adv;
	logic                          ld;
	logic                          m_fire;
	logic                          last_char;
	logic [VALUE_BITS-1:0]         raw;

	logic                          busy_q;
	logic                          neg_pend_q;
	logic [NDIG-1:0][3:0]          dig_q;
	logic [IW-1:0]                 idx_q;

	assign raw       = s_axis_tdata[VALUE_BITS-1:0];
	assign last_char = !neg_pend_q && (idx_q == '0);
	assign m_fire    = busy_q && m_axis_tready;
	assign ld        = vld_a[NDIG] && (!busy_q || (m_axis_tready && last_char));
	assign adv       = !vld_a[NDIG] || ld;
	assign s_axis_tready = adv;

	// magnitude stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= raw[VALUE_BITS-1];
			// the most negative value negates to itself, which is the right magnitude
			quo_s1 <= raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
		end
	end

	assign vld_a[0] = vld_s1;
	assign neg_a[0] = neg_s1;
	assign quo_a[0] = quo_s1;
	assign nd_a[0]  = NDW'(1);
	assign dig_a[0] = '0;

	for (genvar k = 0; k < NDIG; k++) begin : g_digit
		sbad_digit_stage #(
			.VALUE_BITS (VALUE_BITS),
			.NDIG       (NDIG),
			.NDW        (NDW),
			.STAGE      (k)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_i  (vld_a[k]),
			.neg_i  (neg_a[k]),
			.quo_i  (quo_a[k]),
			.nd_i   (nd_a[k]),
			.dig_i  (dig_a[k]),
			.vld_o  (vld_a[k+1]),
			.neg_o  (neg_a[k+1]),
			.quo_o  (quo_a[k+1]),
			.nd_o   (nd_a[k+1]),
			.dig_o  (dig_a[k+1])
		);
	end

	// character sequencer: minus sign first, then digits from the top down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			neg_pend_q <= 1'b0;
			idx_q      <= '0;
		end else if (ld) begin
			busy_q     <= 1'b1;
			neg_pend_q <= neg_a[NDIG];
			idx_q      <= IW'(nd_a[NDIG] - 1'b1);
		end else if (m_fire) begin
			if (last_char) begin
				busy_q <= 1'b0;
			end else if (neg_pend_q) begin
				neg_pend_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			dig_q <= dig_a[NDIG];
		end
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tlast  = last_char;
	assign m_axis_tdata  = neg_pend_q ? MINUS_CODE : (ZERO_CODE + {4'b0000, dig_q[idx_q]});

	a_last_not_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata != MINUS_CODE)
		else $error("minus sign flagged as last character");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == MINUS_CODE) ||
			(m_axis_tdata >= ZERO_CODE && m_axis_tdata <= ZERO_CODE + 8'(RADIX) - 8'd1))
		else $error("character outside minus and digit codes");

	a_text_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && !m_axis_tlast |=> m_axis_tvalid)
		else $error("text dropped before its last character");

endmodule

`default_nettype wire

// ===== design/sbad_digit_stage.sv =====
// ----------------------------------------------------------------------------
// sbad_digit_stage: one divide-by-ten pipeline stage
// Peels off digit STAGE (least significant first) and passes the quotient on.
// ----------------------------------------------------------------------------
`default_nettype none

module sbad_digit_stage #(
	parameter int VALUE_BITS = sbad_pkg::VALUE_BITS_DEFAULT,
	parameter int NDIG       = sbad_pkg::digits_for(sbad_pkg::VALUE_BITS_DEFAULT),
	parameter int NDW        = $clog2(sbad_pkg::digits_for(sbad_pkg::VALUE_BITS_DEFAULT) + 2),
	parameter int STAGE      = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       vld_i,
	input  wire logic                       neg_i,
	input  wire logic [VALUE_BITS-1:0]      quo_i,
	input  wire logic [NDW-1:0]             nd_i,
	input  wire logic [NDIG-1:0][3:0]       dig_i,
	output logic                            vld_o,
	output logic                            neg_o,
	output logic [VALUE_BITS-1:0]           quo_o,
	output logic [NDW-1:0]                  nd_o,
	output logic [NDIG-1:0][3:0]            dig_o
);
	import sbad_pkg::*;

	logic [63:0]             prod;
	logic [VALUE_BITS-1:0]   q;
	logic [VALUE_BITS-1:0]   r;
	logic [NDIG-1:0][3:0]    dig_n;
	logic [NDW-1:0]          nd_n;

	always_comb begin
		prod  = 64'(32'(quo_i)) * 64'(RECIP);
		q     = VALUE_BITS'(prod >> RECIP_SHIFT);
		r     = quo_i - ((q << 3) + (q << 1));
		dig_n = dig_i;
		dig_n[STAGE] = r[3:0];
		// a nonzero quotient means at least one more significant digit
		nd_n  = (q != '0) ? NDW'(STAGE + 2) : nd_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (adv) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_o <= neg_i;
			quo_o <= q;
			nd_o  <= nd_n;
			dig_o <= dig_n;
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for signed_binary_to_ascii_decimal
// Sends signed 16-bit values over the input stream and checks every character
// on the output stream against typed or predicted decimal text. A short table
// of edge values comes first, then random values. Both stream sides idle at
// random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import sbad_pkg::*;

	localparam int VBITS       = 16;
	localparam int NDIG        = 5;
	localparam int LATENCY     = NDIG + 2;
	localparam int LONG_HOLD   = 300;
	localparam int DIR_COUNT   = 22;
	localparam int RAND_BURSTY = 150;
	localparam int RAND_STEADY = 150;
	localparam int RAND_TAIL   = 100;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} text_char_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [VBITS-1:0] s_axis_tdata = '0;   // value
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;        // char_code
	logic             m_axis_tlast;

	text_char_t pending_chars[$];
	int         fail_count = 0;
	bit         idle_on = 1'b1;
	bit         hold_request = 1'b0;
	int         stall_left = 0;

	// edge values; an empty string means the predictor supplies the text
	logic [VBITS-1:0] edge_values[DIR_COUNT] = '{
		16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0009, 16'h000A,
		16'hFFF6, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999, 16'd10000,
		16'hD8F1, 16'hD8F0, 16'h8001, 16'h7FFE, 16'h5555, 16'hAAAA,
		16'h3039, 16'hCFC7
	};
	string edge_texts[DIR_COUNT] = '{
		"0", "1", "-1", "32767", "-32768", "9", "10", "-10",
		"", "", "", "", "", "", "", "", "", "", "", "", "", ""
	};

	signed_binary_to_ascii_decimal #(
		.VALUE_BITS(VBITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Queue the decimal text of one value, sign first, no leading zeros.
	function automatic void predict_decimal_text(input logic [VBITS-1:0] value);
		logic [VBITS-1:0] magnitude;
		logic [7:0]       reversed[12];
		int               ndigits;
		text_char_t       c;
		magnitude = value[VBITS-1] ? (~value + 1'b1) : value;
		ndigits = 0;
		do begin
			reversed[ndigits] = ZERO_CODE + 8'(magnitude % 10);
			ndigits++;
			magnitude = VBITS'(magnitude / 10);
		end while (magnitude != 0);
		if (value[VBITS-1]) begin
			c.char_code = MINUS_CODE;
			c.last = 1'b0;
			pending_chars.push_back(c);
		end
		for (int k = ndigits - 1; k >= 0; k--) begin
			c.char_code = reversed[k];
			c.last = (k == 0);
			pending_chars.push_back(c);
		end
	endfunction

	function automatic void queue_typed_text(input string text);
		text_char_t c;
		for (int i = 0; i < text.len(); i++) begin
			c.char_code = text[i];
			c.last = (i == text.len() - 1);
			pending_chars.push_back(c);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [VBITS-1:0] pick_value();
		int               r;
		logic [VBITS-1:0] v;
		int               pow10;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			v = VBITS'($urandom);
		end else if (r < 8) begin
			v = VBITS'($urandom_range(0, 200));
			if ($urandom_range(0, 1))
				v = -v;
		end else begin
			// land just around a digit-count boundary
			case ($urandom_range(0, 4))
				0: pow10 = 1;
				1: pow10 = 10;
				2: pow10 = 100;
				3: pow10 = 1000;
				default: pow10 = 10000;
			endcase
			v = VBITS'(pow10 + $urandom_range(0, 2) - 1);
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v;
	endfunction

	// Offer one value, hold it until the transfer, then queue its text.
	task automatic send_value(input logic [VBITS-1:0] value, input string text);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		do @(posedge clk); while (!s_axis_tready);
		if (text.len() != 0)
			queue_typed_text(text);
		else
			predict_decimal_text(value);
	endtask

	task automatic wait_drained();
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic check_char();
		text_char_t exp;
		if (pending_chars.size() == 0) begin
			$display("%0t: unexpected character: expected none, actual code %0d last %0b",
				$time, m_axis_tdata, m_axis_tlast);
			fail_count++;
			return;
		end
		exp = pending_chars.pop_front();
		if (m_axis_tdata !== exp.char_code) begin
			$display("%0t: char_code mismatch: expected %0d, actual %0d",
				$time, exp.char_code, m_axis_tdata);
			fail_count++;
		end
		if (m_axis_tlast !== exp.last) begin
			$display("%0t: last mismatch: expected %0b, actual %0b",
				$time, exp.last, m_axis_tlast);
			fail_count++;
		end
	endtask

	// output side: check each transfer, then choose tready for the next cycle
	always begin
		@(posedge clk);
		if (m_axis_tvalid && m_axis_tready)
			check_char();
		if (hold_request) begin
			hold_request = 1'b0;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (!idle_on || $urandom_range(0, 99) < 60) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			stall_left = pick_gap();
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_COUNT; i++)
			send_value(edge_values[i], edge_texts[i]);

		for (int i = 0; i < RAND_BURSTY; i++) begin
			// stall the output long enough to back up the pipeline
			if (i == 20)
				hold_request = 1'b1;
			send_value(pick_value(), "");
		end

		// pause the input until all text is out
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();

		idle_on = 1'b0;
		for (int i = 0; i < RAND_STEADY; i++)
			send_value(pick_value(), "");

		idle_on = 1'b1;
		for (int i = 0; i < RAND_TAIL; i++)
			send_value(pick_value(), "");
		s_axis_tvalid <= 1'b0;

		wait_drained();
		repeat (LATENCY * 4) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout");
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== signed_binary_to_ascii_decimal.f =====
design/sbad_pkg.sv
design/sbad_digit_stage.sv
design/signed_binary_to_ascii_decimal.sv
verif/tb_top.sv
